// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge outside reset
`define TPB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// consequent must hold in the cycle the antecedent holds
`define TPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`endif

// ===== rtl/tpbss_pkg.sv =====
// types and constants for the trend predictor and setting selector
// no dependencies
`timescale 1ns / 1ps
package tpbss_pkg;
  localparam int unsigned KindW = 2;
  localparam logic [1:0] KIND_PERF  = 2'd0;
  localparam logic [1:0] KIND_DIFF  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] SRC_DEFAULT  = 2'd0;
  localparam logic [1:0] SRC_BEST     = 2'd1;
  localparam logic [1:0] SRC_FALLBACK = 2'd2;
  localparam logic [47:0] Q16_ONE = 48'd65536;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  // quotient width of the final division
  localparam int unsigned NumW = 128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] intensity;
    logic [7:0]  threads;
    logic [31:0] hashrate;
    logic signed [15:0] temperature;
    logic [47:0] difficulty;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] best_intensity;
    logic [7:0]  best_threads;
    logic [47:0] predicted_difficulty;
    logic        efficiency_mode;
    logic [1:0]  choice_source;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF_RD, ST_DIFF_ACC, ST_PRED_PREP, ST_DIV, ST_PRED_FIN,
    ST_PERF_RD, ST_PERF_ACC, ST_LAST_RD, ST_SEL_FIN, ST_OUT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic write_perf;
    logic write_diff;
    logic capture;
    logic diff_start;
    logic diff_step;
    logic pred_prep;
    logic div_step;
    logic pred_fin;
    logic perf_start;
    logic perf_step;
    logic last_rd;
    logic sel_fin;
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic diff_done;
    logic div_done;
    logic perf_done;
    logic short_pred;
  } stat_t;
endpackage

// ===== rtl/tpbss_if.sv =====
// valid/ready channel carrying one packed payload
// depends on nothing; payload type set by parameter
`timescale 1ns / 1ps
interface tpbss_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tpbss_ctrl.sv =====
// controller state machine for query sequencing
// depends on tpbss_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpbss_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  tpbss_pkg::stat_t stat_i,
  output tpbss_pkg::cmd_t cmd_o
);
  import tpbss_pkg::*;
  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_PERF: cmd_o.write_perf = 1'b1;
            KIND_DIFF: cmd_o.write_diff = 1'b1;
            KIND_QUERY: begin
              cmd_o.capture = 1'b1;
              cmd_o.diff_start = 1'b1;
              state_d = ST_DIFF_RD;
            end
            default: ;
          endcase
        end
      end
      ST_DIFF_RD: begin
        if (stat_i.diff_done) state_d = ST_PRED_PREP;
        else state_d = ST_DIFF_ACC;
      end
      ST_DIFF_ACC: begin
        cmd_o.diff_step = 1'b1;
        state_d = ST_DIFF_RD;
      end
      ST_PRED_PREP: begin
        cmd_o.pred_prep = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.short_pred || stat_i.div_done) begin
          state_d = ST_PRED_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_PRED_FIN: begin
        cmd_o.pred_fin = 1'b1;
        state_d = ST_PERF_RD;
      end
      ST_PERF_RD: begin
        cmd_o.perf_start = 1'b0;
        if (stat_i.perf_done) state_d = ST_LAST_RD;
        else state_d = ST_PERF_ACC;
      end
      ST_PERF_ACC: begin
        cmd_o.perf_step = 1'b1;
        state_d = ST_PERF_RD;
      end
      ST_LAST_RD: begin
        cmd_o.last_rd = 1'b1;
        state_d = ST_SEL_FIN;
      end
      ST_SEL_FIN: begin
        cmd_o.sel_fin = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_PRED_FIN) cmd_o.perf_start = 1'b1;
  end

  `TPB_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, in_ready_o, state_q == ST_IDLE)
  `TPB_ASSERT(a_out_holds, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `TPB_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o))
endmodule

// ===== rtl/tpbss_dp.sv =====
// datapath: sample windows, line fit accumulation, divider, selection
// depends on tpbss_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tpbss_dp #(
  parameter int unsigned PERF_DEPTH = 1024,
  parameter int unsigned DIFF_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tpbss_pkg::in_beat_t in_i,
  input  logic signed [15:0] target_temperature_i,
  input  tpbss_pkg::cmd_t cmd_i,
  output tpbss_pkg::stat_t stat_o,
  output tpbss_pkg::out_beat_t out_o
);
  import tpbss_pkg::*;
  localparam int unsigned PW = $clog2(PERF_DEPTH);
  localparam int unsigned DW = $clog2(DIFF_DEPTH);
  localparam int unsigned DENW = 2 * (DW + 1);
  localparam int unsigned DIVCW = $clog2(NumW + 1);

  // memories
  logic [71:0] perf_mem [PERF_DEPTH];
  logic [47:0] diff_mem [DIFF_DEPTH];
  logic [71:0] perf_rd_q;
  logic [47:0] diff_rd_q;

  logic [PW-1:0] perf_wp_q, perf_ptr_q, perf_rd_addr;
  logic [PW:0]   perf_cnt_q, perf_i_q;
  logic [DW-1:0] diff_wp_q, diff_ptr_q, diff_rd_addr;
  logic [DW:0]   diff_cnt_q, diff_i_q;
  logic [47:0]   cur_q;

  // fit accumulators
  logic [DW+47:0] sy_q;
  logic [NumW-1:0] sxy_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [DENW-1:0] den_q;
  logic [DENW:0]   rem_q;
  logic [DIVCW-1:0] div_cnt_q;
  logic short_q;
  logic [47:0] pred_q;
  logic eff_q;

  // selection state
  logic found_q;
  logic [31:0] best_rate_q;
  logic [16:0] best_den_q;
  logic [15:0] best_int_q;
  logic [7:0]  best_thr_q;
  out_beat_t res_q;

  // window pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perf_wp_q <= '0;
      perf_cnt_q <= '0;
      diff_wp_q <= '0;
      diff_cnt_q <= '0;
    end else begin
      if (cmd_i.write_perf) begin
        perf_wp_q <= (perf_wp_q == PW'(PERF_DEPTH - 1)) ? '0 : perf_wp_q + 1'b1;
        if (perf_cnt_q != (PW+1)'(PERF_DEPTH)) perf_cnt_q <= perf_cnt_q + 1'b1;
      end
      if (cmd_i.write_diff) begin
        diff_wp_q <= (diff_wp_q == DW'(DIFF_DEPTH - 1)) ? '0 : diff_wp_q + 1'b1;
        if (diff_cnt_q != (DW+1)'(DIFF_DEPTH)) diff_cnt_q <= diff_cnt_q + 1'b1;
      end
    end
  end

  // read addresses: start of the window, newest sample, or walking pointer
  always_comb begin
    logic [PW+1:0] ps;
    logic [DW+1:0] ds;
    ps = {2'b0, perf_wp_q} + (PW+2)'(PERF_DEPTH) - {1'b0, perf_cnt_q};
    ds = {2'b0, diff_wp_q} + (DW+2)'(DIFF_DEPTH) - {1'b0, diff_cnt_q};
    if (ps >= (PW+2)'(PERF_DEPTH)) ps = ps - (PW+2)'(PERF_DEPTH);
    if (ds >= (DW+2)'(DIFF_DEPTH)) ds = ds - (DW+2)'(DIFF_DEPTH);
    if (cmd_i.perf_start) perf_rd_addr = ps[PW-1:0];
    else if (cmd_i.last_rd)
      perf_rd_addr = (perf_wp_q == '0) ? PW'(PERF_DEPTH - 1) : perf_wp_q - 1'b1;
    else perf_rd_addr = perf_ptr_q;
    diff_rd_addr = cmd_i.diff_start ? ds[DW-1:0] : diff_ptr_q;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_perf)
      perf_mem[perf_wp_q] <= {in_i.intensity, in_i.threads, in_i.hashrate,
                              in_i.temperature};
    perf_rd_q <= perf_mem[perf_rd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_diff) diff_mem[diff_wp_q] <= in_i.difficulty;
    diff_rd_q <= diff_mem[diff_rd_addr];
  end

  // fields of the read sample
  logic [15:0] rd_int;
  logic [7:0]  rd_thr;
  logic [31:0] rd_rate;
  logic signed [15:0] rd_temp;
  assign {rd_int, rd_thr, rd_rate, rd_temp} = perf_rd_q;

  // metric compare terms
  logic [16:0] cand_den;
  logic [48:0] lhs, rhs;
  assign cand_den = eff_q ? ({1'b0, rd_int} + 17'd256) : 17'd1;
  assign lhs = rd_rate * best_den_q;
  assign rhs = best_rate_q * cand_den;

  // products for the prediction
  logic [NumW-1:0] p_w, q_w;
  logic [DENW-1:0] nn1;
  logic [DW:0] nm1;
  assign nm1 = diff_cnt_q - 1'b1;
  assign p_w = (sxy_q << 2) + (sxy_q << 1);
  assign q_w = NumW'(sy_q) * NumW'({nm1, 1'b0});
  assign nn1 = DENW'(diff_cnt_q) * DENW'(nm1);

  // final prediction: early value, or saturated quotient
  logic [47:0] pred_fin_w;
  always_comb begin
    if (short_q) pred_fin_w = pred_q;
    else if (quo_q[NumW-1:48] != '0) pred_fin_w = MAX48;
    else if (quo_q[47:0] < Q16_ONE) pred_fin_w = Q16_ONE;
    else pred_fin_w = quo_q[47:0];
  end

  // divider step, one quotient bit a cycle
  logic [DENW:0] rem_sh;
  assign rem_sh = {rem_q[DENW-1:0], num_q[NumW-1]};

  logic [DW+47:0] iy;
  assign iy = (DW+48)'(diff_i_q) * (DW+48)'(diff_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) cur_q <= in_i.difficulty;
    // difficulty walk
    if (cmd_i.diff_start) begin
      diff_ptr_q <= diff_rd_addr;
      diff_i_q <= '0;
      sy_q <= '0;
      sxy_q <= '0;
    end
    if (cmd_i.diff_step) begin
      sy_q <= sy_q + (DW+48)'(diff_rd_q);
      sxy_q <= sxy_q + NumW'(iy);
      diff_i_q <= diff_i_q + 1'b1;
      diff_ptr_q <= ((diff_rd_addr == DW'(DIFF_DEPTH - 1)) ? '0 : diff_rd_addr + 1'b1);
    end
    if (cmd_i.pred_prep) begin
      short_q <= 1'b1;
      num_q <= p_w - q_w;
      den_q <= nn1;
      rem_q <= '0;
      quo_q <= '0;
      div_cnt_q <= '0;
      if (diff_cnt_q == '0) pred_q <= Q16_ONE;
      else if (diff_cnt_q == (DW+1)'(1)) pred_q <= sy_q[47:0];
      else if (p_w <= q_w) pred_q <= Q16_ONE;
      else short_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      div_cnt_q <= div_cnt_q + 1'b1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
    if (cmd_i.pred_fin) pred_q <= pred_fin_w;
    // efficiency decision taken from the final prediction
    if (cmd_i.perf_start) begin
      eff_q <= (53'(pred_fin_w) * 53'd20) > (53'(cur_q) * 53'd21);
      perf_ptr_q <= perf_rd_addr;
      perf_i_q <= '0;
      found_q <= 1'b0;
      best_rate_q <= '0;
      best_den_q <= 17'd1;
    end
    // performance walk
    if (cmd_i.perf_step) begin
      perf_i_q <= perf_i_q + 1'b1;
      perf_ptr_q <= (perf_ptr_q == PW'(PERF_DEPTH - 1)) ? '0 : perf_ptr_q + 1'b1;
      if (rd_temp <= target_temperature_i && (!found_q || lhs > rhs)) begin
        found_q <= 1'b1;
        best_rate_q <= rd_rate;
        best_den_q <= cand_den;
        best_int_q <= rd_int;
        best_thr_q <= rd_thr;
      end
    end
    if (cmd_i.sel_fin) begin
      res_q.predicted_difficulty <= pred_q;
      res_q.efficiency_mode <= eff_q;
      if (perf_cnt_q == '0) begin
        res_q.best_intensity <= eff_q ? 16'd1536 : 16'd2048;
        res_q.best_threads <= 8'd4;
        res_q.choice_source <= SRC_DEFAULT;
      end else if (found_q) begin
        res_q.best_intensity <= best_int_q;
        res_q.best_threads <= best_thr_q;
        res_q.choice_source <= SRC_BEST;
      end else begin
        res_q.best_intensity <= (rd_int < 16'd512) ? 16'd256 : rd_int - 16'd256;
        res_q.best_threads <= (rd_thr < 8'd2) ? 8'd1 : rd_thr - 8'd1;
        res_q.choice_source <= SRC_FALLBACK;
      end
    end
  end

  assign stat_o.diff_done = (diff_i_q == diff_cnt_q);
  assign stat_o.perf_done = (perf_i_q == perf_cnt_q);
  assign stat_o.div_done = (div_cnt_q == DIVCW'(NumW));
  assign stat_o.short_pred = short_q;
  assign out_o = res_q;

  `TPB_ASSERT(a_perf_cnt_bound, clk_i, rst_ni, perf_cnt_q <= (PW+1)'(PERF_DEPTH))
  `TPB_ASSERT(a_diff_cnt_bound, clk_i, rst_ni, diff_cnt_q <= (DW+1)'(DIFF_DEPTH))
  `TPB_ASSERT_IMP(a_walk_bound, clk_i, rst_ni, cmd_i.perf_step, perf_i_q < perf_cnt_q)
endmodule

// ===== rtl/trend_predict_best_setting_select.sv =====
// top level: trend predictor with best-setting selection
// depends on tpbss_pkg, tpbss_if, tpbss_ctrl, tpbss_dp
//
//  channel   dir  payload                                  beat rule
//  in_ch     in   kind,intensity,threads,hashrate,temp,diff  valid & ready
//  out_ch    out  best_intensity,threads,pred,eff,source     valid & ready
//  cfg       in   target_temperature                         cfg_we_i
//
// an add is taken while idle; a query walks the difficulty window, runs the bit-serial divider
// when the fit needs it, walks the performance window and then hands off the result
// reset clears write pointers and counts; stores are not cleared
// a finished result holds in its register until out_ch takes it; no input meanwhile
`timescale 1ns / 1ps
module trend_predict_best_setting_select #(
  parameter int unsigned PERF_DEPTH = 1024,
  parameter int unsigned DIFF_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  tpbss_if.sink   in_ch,
  tpbss_if.source out_ch
);
  import tpbss_pkg::*;
  logic signed [15:0] target_temperature_q;
  cmd_t cmd;
  stat_t stat;
  in_beat_t in_beat;
  out_beat_t out_beat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temperature_q <= 16'sd20480;
    end else if (cfg_we_i) begin
      target_temperature_q <= cfg_wdata_i;
    end
  end

  assign in_beat = in_ch.data;

  tpbss_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_kind_i(in_beat.kind), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  tpbss_dp #(.PERF_DEPTH(PERF_DEPTH), .DIFF_DEPTH(DIFF_DEPTH)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_beat),
    .target_temperature_i(target_temperature_q),
    .cmd_i(cmd), .stat_o(stat), .out_o(out_beat)
  );

  assign out_ch.data = out_beat;
endmodule
